@@ sv/lusc_pkg.sv @@
// Shared constants and types for the unit-square line clipper.
package lusc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int XY_W          = 17;
    localparam int IN_TDATA_W    = 4 * COORD_W;
    localparam int OUT_TDATA_W   = 40;
    localparam int OUT_TUSER_W   = 3;

    typedef enum logic [1:0] {
        KIND_SLOPED,
        KIND_HORIZ,
        KIND_VERT
    } kind_t;

endpackage

@@ sv/lusc_div.sv @@
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module lusc_div #(
    parameter int NW = 49,
    parameter int DW = 33,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [PW-1:0] side_out
);

    logic          v_reg    [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [PW-1:0] side_reg [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic          v_prev;
        logic [NW-1:0] nq_prev;
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] den_prev;
        logic [PW-1:0] side_prev;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign nq_prev   = num;
            assign rem_prev  = '0;
            assign den_prev  = den;
            assign side_prev = side_in;
        end else begin : g_rest
            assign v_prev    = v_reg[i-1];
            assign nq_prev   = nq_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // shift in one numerator bit, subtract when it fits
        assign trial    = {rem_prev, nq_prev[NW-1]};
        assign diff     = trial - {1'b0, den_prev};
        assign ge       = (trial >= {1'b0, den_prev});
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign nq_next  = {nq_prev[NW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[i]   <= nq_next;
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = nq_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

@@ sv/line_unit_square_clip_core.sv @@
// Clips the infinite line through two Q16.16 points against the unit square.
// Throughput: one line per cycle while the sink takes every word; a line with two results
// holds the pipeline while its first word is sent. The single result channel sets the rate;
// the three dividers are fully pipelined.
// Reset: aresetn low at a clock edge clears all valid bits and the output word index.
module line_unit_square_clip_core #(
    parameter int FRAC_BITS = lusc_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lusc_pkg::IN_TDATA_W-1:0]   s_tdata,   // ax, ay, bx, by (32 each)
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lusc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // px[16:0], py[16:0], zero pad
    output logic [lusc_pkg::OUT_TUSER_W-1:0]  m_tuser,   // hit, line_kind[1:0]
    output logic                              m_tlast
);

    localparam int F  = FRAC_BITS;
    localparam int NW = 33 + F;     // dividend magnitude width
    localparam int VW = F + 1;      // width of an in-range coordinate
    localparam int CW = lusc_pkg::COORD_W;
    localparam int XW = lusc_pkg::XY_W;

    localparam logic signed [33:0] ONE_S  = 34'(longint'(1) << F);
    localparam logic [NW-1:0]      ONE_U  = NW'(longint'(1) << F);
    localparam logic [VW-1:0]      ONE_V  = VW'(longint'(1) << F);
    localparam logic [NW-1:0]      MAGMAX = NW'(64'h7FFF_FFFF);
    localparam logic [NW-1:0]      MAGMIN = NW'(64'h8000_0000);
    localparam logic signed [63:0] BIAS   = 64'((longint'(1) << F) - 1);

    localparam logic [1:0] K_SLOPED = lusc_pkg::KIND_SLOPED;
    localparam logic [1:0] K_HORIZ  = lusc_pkg::KIND_HORIZ;
    localparam logic [1:0] K_VERT   = lusc_pkg::KIND_VERT;

    // Whole pipeline advances together; it holds only while the output
    // register keeps a word the sink has not taken.
    logic adv;

    // ---------------- stage 1: capture input word ----------------
    logic                 v1_reg;
    logic signed [CW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;

    // ---------------- stage 2: differences ----------------
    logic                 v2_reg;
    logic signed [32:0]   dx2_reg, dy2_reg;
    logic signed [CW-1:0] ax2_reg, ay2_reg;

    // ---------------- stage 3: slope dividend/divisor magnitudes ----------------
    logic                 v3_reg;
    logic [NW-1:0]        nm3_reg;
    logic [32:0]          dn3_reg;
    logic                 neg3_reg, vert3_reg;
    logic signed [CW-1:0] ax3_reg, ay3_reg;
    logic [32:0]          dy_abs_next, dx_abs_next;

    // slope divider
    logic                 d1_valid;
    logic [NW-1:0]        d1_quo;
    logic [65:0]          d1_side;
    logic                 d1_vert, d1_neg;
    logic signed [CW-1:0] d1_ax, d1_ay;

    // ---------------- stage 4: saturated slope ----------------
    logic                 v4_reg, vert4_reg;
    logic signed [CW-1:0] m4_reg, ax4_reg, ay4_reg;
    logic signed [CW-1:0] m_next;
    logic [NW-1:0]        quo_neg;

    // ---------------- stage 5: m*ax ----------------
    logic                 v5_reg, vert5_reg;
    logic signed [63:0]   p5_reg;
    logic signed [CW-1:0] m5_reg, ax5_reg, ay5_reg;

    // ---------------- stage 6: truncate toward zero ----------------
    logic                 v6_reg, vert6_reg;
    logic signed [63:0]   t6_reg;
    logic signed [CW-1:0] m6_reg, ax6_reg, ay6_reg;
    logic signed [63:0]   t_next;

    // ---------------- stage 7: intercept ----------------
    logic                 v7_reg, vert7_reg;
    logic signed [CW-1:0] c7_reg, m7_reg, ax7_reg;
    logic signed [64:0]   cdiff;
    logic signed [CW-1:0] c_next;

    // ---------------- stage 8: crossing numerators ----------------
    logic                 v8_reg, vert8_reg;
    logic signed [33:0]   u1_8_reg, u3_8_reg;
    logic signed [32:0]   y2_8_reg;
    logic signed [CW-1:0] c8_reg, m8_reg, ax8_reg;

    // ---------------- stage 9: crossing dividend/divisor magnitudes ----------------
    logic                 v9_reg, vert9_reg, neg1_9_reg, neg3_9_reg, mz9_reg;
    logic [NW-1:0]        n1_9_reg, n3_9_reg;
    logic [31:0]          dm9_reg;
    logic signed [CW-1:0] c9_reg, ax9_reg;
    logic signed [32:0]   y2_9_reg;
    logic [33:0]          u1_abs, u3_abs, m_abs;

    // crossing dividers (y=1 edge and y=0 edge)
    logic                 d2_valid, d3_valid;
    logic [NW-1:0]        d2_quo, d3_quo;
    logic [99:0]          d2_side;
    logic [0:0]           d3_side;
    logic                 d2_vert, d2_neg, d2_mz;
    logic signed [CW-1:0] d2_ax, d2_c;
    logic signed [32:0]   d2_y2;

    // ---------------- stage 10: range tests ----------------
    logic                 v10_reg, vert10_reg, mz10_reg;
    logic                 ok_ax10_reg, ok_c10_reg, ok_x1_10_reg, ok_y2_10_reg, ok_x3_10_reg;
    logic [VW-1:0]        ax10_reg, c10_reg, x1_10_reg, y2_10_reg, x3_10_reg;

    // ---------------- output register ----------------
    logic                 em_valid_reg, em_idx_reg, em_two_reg, em_hit_reg;
    logic [1:0]           em_kind_reg;
    logic [XW-1:0]        em_px0_reg, em_py0_reg, em_px1_reg, em_py1_reg;

    logic                 sel_two_next, sel_hit_next;
    logic [1:0]           sel_kind_next;
    logic [VW-1:0]        sel_px0_next, sel_py0_next, sel_px1_next, sel_py1_next;

    // ---------------- combinational datapath ----------------
    assign dy_abs_next = dy2_reg[32] ? 33'(-dy2_reg) : 33'(dy2_reg);
    assign dx_abs_next = dx2_reg[32] ? 33'(-dx2_reg) : 33'(dx2_reg);

    assign {d1_vert, d1_neg, d1_ax, d1_ay} = d1_side;

    // saturate the slope magnitude to the signed 32-bit range
    assign quo_neg = -d1_quo;
    always_comb begin
        if (!d1_neg) begin
            m_next = (d1_quo > MAGMAX) ? 32'sh7FFF_FFFF : $signed(d1_quo[CW-1:0]);
        end else begin
            m_next = (d1_quo > MAGMIN) ? 32'sh8000_0000 : $signed(quo_neg[CW-1:0]);
        end
    end

    // divide by ONE, rounding toward zero
    assign t_next = (p5_reg + (p5_reg[63] ? BIAS : 64'sd0)) >>> F;

    assign cdiff = 65'(ay6_reg) - 65'(t6_reg);
    always_comb begin
        if (cdiff > 65'sh0_7FFF_FFFF) begin
            c_next = 32'sh7FFF_FFFF;
        end else if (cdiff < -65'sh0_8000_0000) begin
            c_next = 32'sh8000_0000;
        end else begin
            c_next = cdiff[CW-1:0];
        end
    end

    assign u1_abs = u1_8_reg[33] ? 34'(-u1_8_reg) : 34'(u1_8_reg);
    assign u3_abs = u3_8_reg[33] ? 34'(-u3_8_reg) : 34'(u3_8_reg);
    assign m_abs  = m8_reg[31] ? -34'(m8_reg) : 34'(m8_reg);

    assign {d2_vert, d2_neg, d2_mz, d2_ax, d2_c, d2_y2} = d2_side;

    // pick the first two distinct in-range hits over the edges x=0, y=1, x=1, y=0 (sloped lines)
    always_comb begin
        logic [VW-1:0] cx [4];
        logic [VW-1:0] cy [4];
        logic          ok [4];
        logic [VW-1:0] hx0, hy0, hx1, hy1;
        logic [1:0]    n;

        cx[0] = '0;           cy[0] = c10_reg;   ok[0] = ok_c10_reg;
        cx[1] = x1_10_reg;    cy[1] = ONE_V;     ok[1] = ok_x1_10_reg;
        cx[2] = ONE_V;        cy[2] = y2_10_reg; ok[2] = ok_y2_10_reg;
        cx[3] = x3_10_reg;    cy[3] = '0;        ok[3] = ok_x3_10_reg;
        hx0 = '0;
        hy0 = '0;
        hx1 = '0;
        hy1 = '0;
        n   = 2'd0;
        for (int e = 0; e < 4; e++) begin
            if (ok[e] && n == 2'd0) begin
                hx0 = cx[e];
                hy0 = cy[e];
                n   = 2'd1;
            end else if (ok[e] && n == 2'd1 && !(hx0 == cx[e] && hy0 == cy[e])) begin
                hx1 = cx[e];
                hy1 = cy[e];
                n   = 2'd2;
            end
        end

        if (vert10_reg) begin
            sel_kind_next = K_VERT;
            sel_hit_next  = ok_ax10_reg;
            sel_two_next  = ok_ax10_reg;
            sel_px0_next  = ok_ax10_reg ? ax10_reg : '0;
            sel_py0_next  = '0;
            sel_px1_next  = ax10_reg;
            sel_py1_next  = ONE_V;
        end else if (mz10_reg) begin
            sel_kind_next = K_HORIZ;
            sel_hit_next  = ok_c10_reg;
            sel_two_next  = ok_c10_reg;
            sel_px0_next  = '0;
            sel_py0_next  = ok_c10_reg ? c10_reg : '0;
            sel_px1_next  = ONE_V;
            sel_py1_next  = c10_reg;
        end else begin
            sel_kind_next = K_SLOPED;
            sel_hit_next  = (n != 2'd0);
            sel_two_next  = (n == 2'd2);
            sel_px0_next  = hx0;
            sel_py0_next  = hy0;
            sel_px1_next  = hx1;
            sel_py1_next  = hy1;
        end
    end

    // ---------------- handshake ----------------
    assign m_tlast  = !em_two_reg || em_idx_reg;
    assign adv      = !em_valid_reg || (m_tready && m_tlast);
    assign s_tready = adv;
    assign m_tvalid = em_valid_reg;
    assign m_tuser  = {em_kind_reg, em_hit_reg};
    assign m_tdata  = em_idx_reg
                    ? lusc_pkg::OUT_TDATA_W'({em_py1_reg, em_px1_reg})
                    : lusc_pkg::OUT_TDATA_W'({em_py0_reg, em_px0_reg});

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (adv) begin
            v1_reg  <= s_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= d1_valid;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= d2_valid && d3_valid;
        end
    end

    // ---------------- payload stages ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax1_reg <= s_tdata[CW-1:0];
            ay1_reg <= s_tdata[2*CW-1:CW];
            bx1_reg <= s_tdata[3*CW-1:2*CW];
            by1_reg <= s_tdata[4*CW-1:3*CW];

            dx2_reg <= 33'(bx1_reg) - 33'(ax1_reg);
            dy2_reg <= 33'(by1_reg) - 33'(ay1_reg);
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;

            nm3_reg   <= {dy_abs_next, {F{1'b0}}};
            dn3_reg   <= dx_abs_next;
            neg3_reg  <= dy2_reg[32] ^ dx2_reg[32];
            vert3_reg <= (dx2_reg == 33'sd0);
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;

            m4_reg    <= m_next;
            ax4_reg   <= d1_ax;
            ay4_reg   <= d1_ay;
            vert4_reg <= d1_vert;

            p5_reg    <= 64'(m4_reg) * 64'(ax4_reg);
            m5_reg    <= m4_reg;
            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
            vert5_reg <= vert4_reg;

            t6_reg    <= t_next;
            m6_reg    <= m5_reg;
            ax6_reg   <= ax5_reg;
            ay6_reg   <= ay5_reg;
            vert6_reg <= vert5_reg;

            c7_reg    <= c_next;
            m7_reg    <= m6_reg;
            ax7_reg   <= ax6_reg;
            vert7_reg <= vert6_reg;

            u1_8_reg  <= ONE_S - 34'(c7_reg);
            u3_8_reg  <= -34'(c7_reg);
            y2_8_reg  <= 33'(c7_reg) + 33'(m7_reg);
            c8_reg    <= c7_reg;
            m8_reg    <= m7_reg;
            ax8_reg   <= ax7_reg;
            vert8_reg <= vert7_reg;

            n1_9_reg   <= {u1_abs[32:0], {F{1'b0}}};
            n3_9_reg   <= {u3_abs[32:0], {F{1'b0}}};
            dm9_reg    <= m_abs[31:0];
            neg1_9_reg <= u1_8_reg[33] ^ m8_reg[31];
            neg3_9_reg <= u3_8_reg[33] ^ m8_reg[31];
            mz9_reg    <= (m8_reg == 32'sd0);
            c9_reg     <= c8_reg;
            ax9_reg    <= ax8_reg;
            y2_9_reg   <= y2_8_reg;
            vert9_reg  <= vert8_reg;

            // an in-range value keeps its range after saturation, so test the raw one
            ok_ax10_reg  <= !d2_ax[31] && 34'(d2_ax) <= ONE_S;
            ok_c10_reg   <= !d2_c[31] && 34'(d2_c) <= ONE_S;
            ok_y2_10_reg <= !d2_y2[32] && 34'(d2_y2) <= ONE_S;
            ok_x1_10_reg <= (!d2_neg || d2_quo == '0) && d2_quo <= ONE_U;
            ok_x3_10_reg <= (!d3_side[0] || d3_quo == '0) && d3_quo <= ONE_U;
            ax10_reg     <= d2_ax[VW-1:0];
            c10_reg      <= d2_c[VW-1:0];
            y2_10_reg    <= d2_y2[VW-1:0];
            x1_10_reg    <= d2_quo[VW-1:0];
            x3_10_reg    <= d3_quo[VW-1:0];
            vert10_reg   <= d2_vert;
            mz10_reg     <= d2_mz;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
            em_idx_reg   <= 1'b0;
        end else if (adv) begin
            em_valid_reg <= v10_reg;
            em_idx_reg   <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            // first of two words taken, advance to the second
            em_idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            em_two_reg  <= sel_two_next;
            em_hit_reg  <= sel_hit_next;
            em_kind_reg <= sel_kind_next;
            em_px0_reg  <= XW'(32'(sel_px0_next));
            em_py0_reg  <= XW'(32'(sel_py0_next));
            em_px1_reg  <= XW'(32'(sel_px1_next));
            em_py1_reg  <= XW'(32'(sel_py1_next));
        end
    end

    // ---------------- dividers ----------------
    lusc_div #(
        .NW (NW),
        .DW (33),
        .PW (66)
    ) u_div_slope (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3_reg),
        .num       (nm3_reg),
        .den       (dn3_reg),
        .side_in   ({vert3_reg, neg3_reg, ax3_reg, ay3_reg}),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .side_out  (d1_side)
    );

    lusc_div #(
        .NW (NW),
        .DW (32),
        .PW (100)
    ) u_div_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v9_reg),
        .num       (n1_9_reg),
        .den       (dm9_reg),
        .side_in   ({vert9_reg, neg1_9_reg, mz9_reg, ax9_reg, c9_reg, y2_9_reg}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side)
    );

    lusc_div #(
        .NW (NW),
        .DW (32),
        .PW (1)
    ) u_div_bot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v9_reg),
        .num       (n3_9_reg),
        .den       (dm9_reg),
        .side_in   (neg3_9_reg),
        .out_valid (d3_valid),
        .quo       (d3_quo),
        .side_out  (d3_side)
    );

`ifndef SYNTHESIS
    // second word of a pair only exists for two-result lines
    a_idx_two: assert property (@(posedge aclk) disable iff (!aresetn)
        em_idx_reg |-> (em_two_reg && em_valid_reg))
        else $error("second word selected for single-result line");

    // a miss is always the only word of its line
    a_miss_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tlast)
        else $error("miss word without tlast");

    // after the first of two words is taken, the second follows
    a_pair_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && em_idx_reg))
        else $error("second word of pair lost");
`endif

endmodule
